[rtl/core/wlps_pkg.sv]
package wlps_pkg;

	localparam int BYTE_W = 8;
	localparam int OFS_W  = 8;
	localparam int POS_W  = 8;
	localparam int BOOT_W = 7;
	localparam int PC_W   = 5;

	localparam logic [BYTE_W-1:0] BYTE_ERASED = 8'hFF;

	typedef enum logic [1:0] {
		F_SAVE  = 2'd0,
		F_READ  = 2'd1,
		F_CLEAR = 2'd2,
		F_POWER = 2'd3
	} func_t;

	typedef logic [PC_W-1:0] pc_t;

	// microprogram addresses
	localparam pc_t P_IDLE    = 5'd0;
	localparam pc_t P_SAVE    = 5'd1;
	localparam pc_t P_PEND    = 5'd2;
	localparam pc_t P_BASE    = 5'd3;
	localparam pc_t P_WALK    = 5'd4;
	localparam pc_t P_SH_AD   = 5'd5;
	localparam pc_t P_SH_RD   = 5'd6;
	localparam pc_t P_SH_WR   = 5'd7;
	localparam pc_t P_ADV     = 5'd8;
	localparam pc_t P_OBYTE   = 5'd9;
	localparam pc_t P_CLEAR   = 5'd10;
	localparam pc_t P_POWER   = 5'd11;
	localparam pc_t P_REF     = 5'd12;
	localparam pc_t P_REF_RD  = 5'd13;
	localparam pc_t P_REF_WR  = 5'd14;
	localparam pc_t P_REF_END = 5'd15;
	localparam pc_t P_WR_BASE = 5'd16;
	localparam pc_t P_WR_SEL  = 5'd17;
	localparam pc_t P_WR_ADDR = 5'd18;
	localparam pc_t P_WR_DATA = 5'd19;
	localparam pc_t P_DONE    = 5'd20;

	typedef enum logic [2:0] {
		PTR_HOLD, PTR_BASE, PTR_INC, PTR_DEC, PTR_SERVO
	} ptr_op_t;

	typedef enum logic [1:0] {
		CNT_HOLD, CNT_CLR, CNT_INC, CNT_DEC
	} cnt_op_t;

	typedef enum logic [1:0] {
		WR_NONE, WR_COPY, WR_VALUE
	} wr_src_t;

	typedef enum logic [1:0] {
		OFS_HOLD, OFS_ADV, OFS_ONE, OFS_LOAD
	} ofs_op_t;

	typedef enum logic [1:0] {
		OB_HOLD, OB_OFS, OB_ERASE
	} obyte_op_t;

	typedef enum logic [1:0] {
		PEND_HOLD, PEND_SET, PEND_CLR
	} pend_op_t;

	typedef enum logic [2:0] {
		C_NEVER, C_ALWAYS, C_BAD, C_NO_PEND, C_NOT_TOP, C_NOT_ONE, C_NOT_SAVE
	} cond_t;

	typedef struct packed {
		ptr_op_t   ptr;
		cnt_op_t   cnt;
		logic      wa_ld;
		wr_src_t   wr;
		logic      cache_wr;
		ofs_op_t   ofs;
		obyte_op_t obyte;
		pend_op_t  pend;
		logic      vclr;
		cond_t     cond;
		pc_t       target;
		logic      emit;
	} ctl_t;

	typedef struct packed {
		logic ok;
		logic pend;
		logic save;
		logic cnt_top;
		logic cnt_one;
	} sts_t;

	localparam ctl_t CTL_NOP = '{
		ptr: PTR_HOLD, cnt: CNT_HOLD, wa_ld: 1'b0, wr: WR_NONE, cache_wr: 1'b0,
		ofs: OFS_HOLD, obyte: OB_HOLD, pend: PEND_HOLD, vclr: 1'b0,
		cond: C_NEVER, target: P_IDLE, emit: 1'b0
	};

	function automatic pc_t entry(func_t f);
		pc_t p;
		unique case (f)
			F_SAVE:  p = P_SAVE;
			F_READ:  p = P_DONE;
			F_CLEAR: p = P_CLEAR;
			F_POWER: p = P_POWER;
			default: p = P_DONE;
		endcase
		return p;
	endfunction

	// control store
	function automatic ctl_t ucode(pc_t pc);
		ctl_t w;
		w = CTL_NOP;
		unique case (pc)
			P_SAVE: begin
				w.cond = C_BAD; w.target = P_DONE;
			end
			P_PEND: begin
				w.cond = C_NO_PEND; w.target = P_WR_BASE;
			end
			P_BASE: begin
				w.ptr = PTR_BASE; w.cnt = CNT_CLR;
			end
			P_WALK: begin
				w.ptr = PTR_INC; w.cnt = CNT_INC;
				w.cond = C_NOT_TOP; w.target = P_WALK;
			end
			P_SH_AD: begin
				w.wa_ld = 1'b1; w.ptr = PTR_DEC;
			end
			P_SH_WR: begin
				w.wr = WR_COPY; w.cnt = CNT_DEC;
				w.cond = C_NOT_ONE; w.target = P_SH_AD;
			end
			P_ADV: begin
				w.ofs = OFS_ADV; w.pend = PEND_CLR;
			end
			P_OBYTE: begin
				w.obyte = OB_OFS; w.cond = C_ALWAYS; w.target = P_REF;
			end
			P_CLEAR: begin
				w.vclr = 1'b1; w.obyte = OB_ERASE; w.ofs = OFS_ONE;
				w.pend = PEND_SET; w.cond = C_ALWAYS; w.target = P_REF;
			end
			P_POWER: begin
				w.ofs = OFS_LOAD; w.pend = PEND_SET;
			end
			P_REF: begin
				w.ptr = PTR_BASE; w.cnt = CNT_CLR;
			end
			P_REF_WR: begin
				w.cache_wr = 1'b1; w.cnt = CNT_INC; w.ptr = PTR_INC;
				w.cond = C_NOT_TOP; w.target = P_REF_RD;
			end
			P_REF_END: begin
				w.cond = C_NOT_SAVE; w.target = P_DONE;
			end
			P_WR_BASE: w.ptr = PTR_BASE;
			P_WR_SEL:  w.ptr = PTR_SERVO;
			P_WR_ADDR: w.wa_ld = 1'b1;
			P_WR_DATA: w.wr = WR_VALUE;
			P_DONE:    w.emit = 1'b1;
			default:   w = CTL_NOP;
		endcase
		return w;
	endfunction

endpackage

[rtl/core/wlps_if.sv]
interface wlps_req_if;
	logic       valid;
	logic       ready;
	logic [1:0] func;
	logic       servo;
	logic [7:0] value;

	modport source (output valid, func, servo, value, input ready);
	modport sink (input valid, func, servo, value, output ready);
endinterface

interface wlps_rsp_if;
	logic       valid;
	logic       ready;
	logic [7:0] position;
	logic [6:0] boot_offset;

	modport source (output valid, position, boot_offset, input ready);
	modport sink (input valid, position, boot_offset, output ready);
endinterface

[rtl/core/wlps_useq.sv]
module wlps_useq (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             go,
	input  wlps_pkg::func_t  go_func,
	input  wlps_pkg::sts_t   sts,
	input  logic             emit_ok,
	output wlps_pkg::ctl_t   ctl,
	output logic             idle
);
	import wlps_pkg::*;

	pc_t  pc_q;
	pc_t  pc_d;
	logic taken;

	assign ctl  = ucode(pc_q);
	assign idle = (pc_q == P_IDLE);

	always_comb begin
		unique case (ctl.cond)
			C_NEVER:    taken = 1'b0;
			C_ALWAYS:   taken = 1'b1;
			C_BAD:      taken = !sts.ok;
			C_NO_PEND:  taken = !sts.pend;
			C_NOT_TOP:  taken = !sts.cnt_top;
			C_NOT_ONE:  taken = !sts.cnt_one;
			C_NOT_SAVE: taken = !sts.save;
			default:    taken = 1'b0;
		endcase
	end

	always_comb begin
		pc_d = pc_q;
		priority if (pc_q == P_IDLE) begin
			if (go) pc_d = entry(go_func);
		end else if (ctl.emit) begin
			// hold on the final step until the result register frees up
			if (emit_ok) pc_d = P_IDLE;
		end else if (taken) begin
			pc_d = ctl.target;
		end else begin
			pc_d = pc_q + pc_t'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q <= P_IDLE;
		end else begin
			pc_q <= pc_d;
		end
	end

endmodule

[rtl/core/wlps_dpath.sv]
module wlps_dpath #(
	parameter int RING_SLOTS  = 64,
	parameter int SERVO_COUNT = 2
) (
	input  logic           clk,
	input  logic           arst_n,
	input  wlps_pkg::ctl_t ctl,
	input  logic           load,
	input  logic [1:0]     in_func,
	input  logic           in_servo,
	input  logic [7:0]     in_value,
	output wlps_pkg::sts_t sts,
	output logic [7:0]     position,
	output logic [6:0]     boot_offset
);
	import wlps_pkg::*;

	localparam int IDX_W  = $clog2(RING_SLOTS);
	localparam int CNT_W  = $clog2(SERVO_COUNT + 1);
	localparam int CIDX_W = (SERVO_COUNT > 1) ? $clog2(SERVO_COUNT) : 1;
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(RING_SLOTS - 1);

	// latched request
	func_t             func_q;
	logic              servo_q;
	logic [BYTE_W-1:0] value_q;

	logic [IDX_W-1:0]  ptr_q, ptr_d, ptr_inc, ptr_dec, base;
	logic [IDX_W-1:0]  wa_q;
	logic [CNT_W-1:0]  cnt_q, cnt_d;
	logic [OFS_W-1:0]  ofs_q, ofs_d, ofs_adv, ofs_ld;
	logic [BYTE_W-1:0] obyte_q;
	logic              pend_q;
	logic [POS_W-1:0]  cache_q [SERVO_COUNT];

	logic [BYTE_W-1:0] mem [RING_SLOTS];
	logic [RING_SLOTS-1:0] vld_q;
	logic [BYTE_W-1:0] rdata_q;
	logic              rvld_q;
	logic [BYTE_W-1:0] raw, cval, wdata;
	logic              wr_en;
	logic              ok;

	always_ff @(posedge clk) begin
		if (load) begin
			func_q  <= func_t'(in_func);
			servo_q <= in_servo;
			value_q <= in_value;
		end
	end

	assign ok = (int'(servo_q) < SERVO_COUNT);

	// ring pointer arithmetic, wrapping at the ring size
	assign base    = IDX_W'(ofs_q - OFS_W'(1));
	assign ptr_inc = (ptr_q == LAST_IDX) ? '0 : ptr_q + IDX_W'(1);
	assign ptr_dec = (ptr_q == '0) ? LAST_IDX : ptr_q - IDX_W'(1);

	always_comb begin
		unique case (ctl.ptr)
			PTR_HOLD:  ptr_d = ptr_q;
			PTR_BASE:  ptr_d = base;
			PTR_INC:   ptr_d = ptr_inc;
			PTR_DEC:   ptr_d = ptr_dec;
			PTR_SERVO: ptr_d = servo_q ? ptr_inc : ptr_q;
			default:   ptr_d = ptr_q;
		endcase
	end

	always_comb begin
		unique case (ctl.cnt)
			CNT_HOLD: cnt_d = cnt_q;
			CNT_CLR:  cnt_d = '0;
			CNT_INC:  cnt_d = cnt_q + CNT_W'(1);
			CNT_DEC:  cnt_d = cnt_q - CNT_W'(1);
			default:  cnt_d = cnt_q;
		endcase
	end

	assign ofs_adv = (ofs_q >= OFS_W'(RING_SLOTS)) ? OFS_W'(1) : ofs_q + OFS_W'(1);
	assign ofs_ld  = (obyte_q == '0 || obyte_q == BYTE_ERASED ||
		obyte_q > OFS_W'(RING_SLOTS)) ? OFS_W'(1) : obyte_q;

	always_comb begin
		unique case (ctl.ofs)
			OFS_HOLD: ofs_d = ofs_q;
			OFS_ADV:  ofs_d = ofs_adv;
			OFS_ONE:  ofs_d = OFS_W'(1);
			OFS_LOAD: ofs_d = ofs_ld;
			default:  ofs_d = ofs_q;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ptr_q   <= '0;
			wa_q    <= '0;
			cnt_q   <= '0;
			ofs_q   <= OFS_W'(1);
			obyte_q <= BYTE_ERASED;
			pend_q  <= 1'b1;
		end else begin
			ptr_q <= ptr_d;
			cnt_q <= cnt_d;
			ofs_q <= ofs_d;
			if (ctl.wa_ld) wa_q <= ptr_q;
			unique case (ctl.obyte)
				OB_OFS:   obyte_q <= ofs_q;
				OB_ERASE: obyte_q <= BYTE_ERASED;
				default:  obyte_q <= obyte_q;
			endcase
			unique case (ctl.pend)
				PEND_SET: pend_q <= 1'b1;
				PEND_CLR: pend_q <= 1'b0;
				default:  pend_q <= pend_q;
			endcase
		end
	end

	// slot ring; a slot not written since the last erase reads as erased
	assign raw   = rvld_q ? rdata_q : BYTE_ERASED;
	assign cval  = (raw == BYTE_ERASED) ? '0 : raw;
	assign wr_en = (ctl.wr != WR_NONE);
	assign wdata = (ctl.wr == WR_VALUE) ? value_q : raw;

	always_ff @(posedge clk) begin
		if (wr_en) mem[wa_q] <= wdata;
		rdata_q <= mem[ptr_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q  <= '0;
			rvld_q <= 1'b0;
		end else begin
			if (ctl.vclr) begin
				vld_q <= '0;
			end else if (wr_en) begin
				vld_q[wa_q] <= 1'b1;
			end
			rvld_q <= vld_q[ptr_q];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < SERVO_COUNT; i++) cache_q[i] <= '0;
		end else if (ctl.cache_wr) begin
			cache_q[cnt_q[CIDX_W-1:0]] <= cval;
		end
	end

	assign sts.ok      = ok;
	assign sts.pend    = pend_q;
	assign sts.save    = (func_q == F_SAVE);
	assign sts.cnt_top = (cnt_q == CNT_W'(SERVO_COUNT - 1));
	assign sts.cnt_one = (cnt_q == CNT_W'(1));

	assign position    = ok ? cache_q[CIDX_W'(servo_q)] : '0;
	assign boot_offset = ofs_q[BOOT_W-1:0];

	a_ofs_range: assert property (@(posedge clk) disable iff (!arst_n)
		ofs_q != '0 && ofs_q <= OFS_W'(RING_SLOTS))
		else $error("ring offset out of range");

	a_ofs_adv: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.ofs == OFS_ADV |=> ofs_q != $past(ofs_q))
		else $error("offset advance left offset unchanged");

	a_ptr_range: assert property (@(posedge clk) disable iff (!arst_n)
		int'(ptr_q) < RING_SLOTS && int'(wa_q) < RING_SLOTS)
		else $error("slot pointer beyond ring");

	a_copy_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.wr == WR_COPY |-> cnt_q != '0)
		else $error("slot copy with exhausted servo count");

endmodule

[rtl/core/wear_leveled_position_store.sv]
// Channel  Dir  Modport  Payload                          Transaction when
// req      in   sink     func[1:0] servo value[7:0]       req.valid && req.ready
// rsp      out  source   position[7:0] boot_offset[6:0]   rsp.valid && rsp.ready
//
// Each request runs a short microprogram; one result per request.
// The first save after power-up or clear also runs a pending shift of the
// stored bytes; clear and power-up refill the position cache. The slot memory
// has one read and one write port; each shifted byte goes through an address,
// a read and a write step, each cached byte through a read and a write step.
// arst_n erases the ring at once through per-slot valid bits; no clear pass.
// A result not yet taken holds the program on its final step; a new request
// is taken whenever the program is idle, even while a result waits.
module wear_leveled_position_store #(
	parameter int RING_SLOTS  = 64,
	parameter int SERVO_COUNT = 2
) (
	input logic         clk,
	input logic         arst_n,
	wlps_req_if.sink    req,
	wlps_rsp_if.source  rsp
);
	import wlps_pkg::*;

	ctl_t              ctl;
	sts_t              sts;
	logic              idle;
	logic              accept;
	logic              emit_ok;
	logic              fire;
	logic [POS_W-1:0]  position;
	logic [BOOT_W-1:0] boot_offset;

	logic              out_vld_q;
	logic [POS_W-1:0]  pos_q;
	logic [BOOT_W-1:0] boff_q;

	// take a request only between programs
	assign req.ready = idle;
	assign accept    = req.valid && req.ready;

	// the result register frees up when empty or being drained this cycle
	assign emit_ok = !out_vld_q || rsp.ready;
	assign fire    = ctl.emit && emit_ok;

	wlps_useq u_useq (
		.clk     (clk),
		.arst_n  (arst_n),
		.go      (accept),
		.go_func (func_t'(req.func)),
		.sts     (sts),
		.emit_ok (emit_ok),
		.ctl     (ctl),
		.idle    (idle)
	);

	wlps_dpath #(
		.RING_SLOTS  (RING_SLOTS),
		.SERVO_COUNT (SERVO_COUNT)
	) u_dpath (
		.clk         (clk),
		.arst_n      (arst_n),
		.ctl         (ctl),
		.load        (accept),
		.in_func     (req.func),
		.in_servo    (req.servo),
		.in_value    (req.value),
		.sts         (sts),
		.position    (position),
		.boot_offset (boot_offset)
	);

	// result register: advance on fire, drop valid once taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else begin
			if (fire) begin
				out_vld_q <= 1'b1;
			end else if (rsp.ready) begin
				out_vld_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			pos_q  <= position;
			boff_q <= boot_offset;
		end
	end

	assign rsp.valid       = out_vld_q;
	assign rsp.position    = pos_q;
	assign rsp.boot_offset = boff_q;

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> !req.ready)
		else $error("request port ready right after a transaction");

	a_fire_fills: assert property (@(posedge clk) disable iff (!arst_n)
		fire |=> rsp.valid)
		else $error("result lost on its way to the output register");

	a_emit_holds: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.emit && !emit_ok |=> ctl.emit)
		else $error("final step left while the result register was full");

endmodule
